### hdl/pxsc_pkg.sv
// ----------------------------------------------------------------------------
// pxsc_pkg
// Shared widths, types and helpers for the prefix-XOR subarray counter.
// ----------------------------------------------------------------------------
`default_nettype none

package pxsc_pkg;

    localparam int VALUE_BITS  = 8;
    localparam int FIELD_BITS  = 8;
    localparam int HIST_DEPTH  = 1 << VALUE_BITS;
    localparam int HIST_BITS   = 13;
    localparam int TOTAL_BITS  = 24;

    localparam logic [HIST_BITS-1:0]  HIST_MAX  = {HIST_BITS{1'b1}};
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

    typedef logic [VALUE_BITS-1:0] t_key;
    typedef logic [HIST_BITS-1:0]  t_hcnt;
    typedef logic [TOTAL_BITS-1:0] t_total;

    // read request: both addresses go out on the same edge
    typedef struct packed {
        logic en;
        t_key seek;
        t_key pref;
    } t_hist_rd;

    // write of one entry; clr drops every other entry back to its reset value
    typedef struct packed {
        logic  en;
        logic  clr;
        t_key  addr;
        t_hcnt data;
    } t_hist_wr;

    // reset value of a histogram entry: the empty prefix is seen once
    function automatic t_hcnt hist_default(input t_key key);
        return (key == '0) ? t_hcnt'(1) : t_hcnt'(0);
    endfunction

endpackage

`default_nettype wire

### hdl/pxsc_in_if.sv
// ----------------------------------------------------------------------------
// pxsc_in_if
// Valid/ready channel carrying one array element per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pxsc_in_if;
    import pxsc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] value;
    logic                  first;
    logic                  last;

    modport source (output valid, output value, output first, output last, input ready);
    modport sink   (input valid, input value, input first, input last, output ready);
endinterface

`default_nettype wire

### hdl/pxsc_out_if.sv
// ----------------------------------------------------------------------------
// pxsc_out_if
// Valid/ready channel carrying one running count per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pxsc_out_if;
    import pxsc_pkg::*;

    logic   valid;
    logic   ready;
    t_total match_count;
    logic   done_res;

    modport source (output valid, output match_count, output done_res, input ready);
    modport sink   (input valid, input match_count, input done_res, output ready);
endinterface

`default_nettype wire

### hdl/pxsc_hist_store.sv
// ----------------------------------------------------------------------------
// pxsc_hist_store
// Prefix histogram: dual-read single-write RAM, per-entry valid flags and
// forwarding of the write that coincides with a read.
// ----------------------------------------------------------------------------
`default_nettype none

module pxsc_hist_store
    import pxsc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_hist_rd i_rd,
    input  wire t_hist_wr i_wr,
    output t_hcnt         o_cnt_seek,
    output t_hcnt         o_cnt_pref
);

    t_hcnt                 r_mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] r_valid;

    t_hcnt r_raw_seek, r_raw_pref;
    logic  r_v_seek, r_v_pref;
    t_key  r_addr_seek, r_addr_pref;
    logic  r_fwd_we, r_fwd_clr;
    t_key  r_fwd_addr;
    t_hcnt r_fwd_data;

    // RAM: read data registered, old data on a same-edge collision
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_raw_seek <= r_mem[i_rd.seek];
            r_raw_pref <= r_mem[i_rd.pref];
        end
    end

    // drop every flag on a clear, then mark the written entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid <= (i_wr.clr ? '0 : r_valid)
                     | ({{(HIST_DEPTH-1){1'b0}}, 1'b1} << i_wr.addr);
        end
    end

    // capture read side info and the write that lands on the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_we  <= 1'b0;
            r_fwd_clr <= 1'b0;
        end else if (i_rd.en) begin
            r_fwd_we  <= i_wr.en;
            r_fwd_clr <= i_wr.en & i_wr.clr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_v_seek    <= r_valid[i_rd.seek];
            r_v_pref    <= r_valid[i_rd.pref];
            r_addr_seek <= i_rd.seek;
            r_addr_pref <= i_rd.pref;
            r_fwd_addr  <= i_wr.addr;
            r_fwd_data  <= i_wr.data;
        end
    end

    always_comb begin
        priority if (r_fwd_we && r_fwd_addr == r_addr_seek) begin
            o_cnt_seek = r_fwd_data;
        end else if (r_fwd_clr || !r_v_seek) begin
            o_cnt_seek = hist_default(r_addr_seek);
        end else begin
            o_cnt_seek = r_raw_seek;
        end
    end

    always_comb begin
        priority if (r_fwd_we && r_fwd_addr == r_addr_pref) begin
            o_cnt_pref = r_fwd_data;
        end else if (r_fwd_clr || !r_v_pref) begin
            o_cnt_pref = hist_default(r_addr_pref);
        end else begin
            o_cnt_pref = r_raw_pref;
        end
    end

endmodule

`default_nettype wire

### hdl/prefix_xor_subarray_counter.sv
// ----------------------------------------------------------------------------
// prefix_xor_subarray_counter
// Counts subarrays whose XOR equals a programmable target, one element per
// cycle unless o_res stalls, the prefix histogram held in a synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   i_item carries one array element per transaction (value, first, last).
//   o_res returns one transaction per element: the running count of
//   subarrays whose XOR equals the target (saturating) and done_res = last.
//   The target is written through i_cfg_we / i_cfg_data while idle and takes
//   effect from the next element.
// Timing:
//   One element per cycle sustained while o_res is taken. An accepted
//   element passes the RAM read stage, then the output register, on its
//   way to o_res. The rate is set by the histogram RAM: one two-address
//   read, one write per cycle, the coinciding write forwarded to the read.
// Reset:
//   Synchronous, active low. Prefix, total and target go to zero; the
//   per-entry valid flags drop at once so every entry reads as its reset
//   value (entry zero one, others zero). No clearing pass is needed.
//   An element marked first clears prefix, total and histogram alike, not the target.
// Back-pressure:
//   A stalled receiver holds the output register; the read stage keeps one
//   more element, and i_item.ready drops only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module prefix_xor_subarray_counter
    import pxsc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [FIELD_BITS-1:0] i_cfg_data,
    pxsc_in_if.sink                    i_item,
    pxsc_out_if.source                 o_res
);

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        t_key seek;
        t_key pref;
    } t_stage;

    t_key   r_target;
    t_key   r_prefix, n_prefix;
    t_total r_total, n_total;
    t_stage r_s1;
    logic   r_out_valid;
    t_total r_out_count;
    logic   r_out_done;

    logic     out_ok, s1_move, in_fire;
    t_hist_rd hist_rd;
    t_hist_wr hist_wr;
    t_hcnt    st_seek, st_pref, cnt_seek, cnt_pref;
    t_total   base_total;
    logic [TOTAL_BITS:0] sum;
    t_key     elem;

    // handshake: output register frees when empty or taken
    assign out_ok  = !r_out_valid || o_res.ready;
    assign s1_move = r_s1.valid && out_ok;
    assign i_item.ready = !r_s1.valid || out_ok;
    assign in_fire = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (i_cfg_we) begin
            r_target <= i_cfg_data[VALUE_BITS-1:0];
        end
    end

    // stage 0: advance the prefix and issue both histogram reads
    assign elem     = i_item.value[VALUE_BITS-1:0];
    assign n_prefix = (i_item.first ? t_key'(0) : r_prefix) ^ elem;

    always_comb begin
        hist_rd.en   = in_fire;
        hist_rd.pref = n_prefix;
        hist_rd.seek = n_prefix ^ r_target;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix   <= '0;
            r_s1.valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_prefix   <= n_prefix;
                r_s1.first <= i_item.first;
                r_s1.last  <= i_item.last;
                r_s1.seek  <= hist_rd.seek;
                r_s1.pref  <= hist_rd.pref;
            end
            if (in_fire || s1_move) begin
                r_s1.valid <= in_fire;
            end
        end
    end

    pxsc_hist_store u_hist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd       (hist_rd),
        .i_wr       (hist_wr),
        .o_cnt_seek (st_seek),
        .o_cnt_pref (st_pref)
    );

    // stage 1: a first element sees a freshly cleared histogram
    assign cnt_seek = r_s1.first ? hist_default(r_s1.seek) : st_seek;
    assign cnt_pref = r_s1.first ? hist_default(r_s1.pref) : st_pref;

    assign base_total = r_s1.first ? t_total'(0) : r_total;
    assign sum        = {1'b0, base_total} + {{(TOTAL_BITS + 1 - HIST_BITS){1'b0}}, cnt_seek};
    assign n_total    = sum[TOTAL_BITS] ? TOTAL_MAX : sum[TOTAL_BITS-1:0];

    // write back the incremented entry as the element leaves stage 1
    always_comb begin
        hist_wr.en   = s1_move;
        hist_wr.clr  = r_s1.first;
        hist_wr.addr = r_s1.pref;
        hist_wr.data = (cnt_pref == HIST_MAX) ? HIST_MAX : cnt_pref + t_hcnt'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_move) begin
                r_total <= n_total;
            end
            if (out_ok) begin
                r_out_valid <= r_s1.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_count <= n_total;
            r_out_done  <= r_s1.last;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.match_count = r_out_count;
    assign o_res.done_res    = r_out_done;

`ifndef SYNTH
    // the total only grows inside one array
    a_total_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move && !r_s1.first |=> r_total >= $past(r_total))
        else $error("running total decreased without a first element");

    // a written histogram entry has been seen at least once
    a_hist_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hist_wr.en |-> hist_wr.data != '0)
        else $error("histogram write of zero");

    // the first element of an array can match at most the empty prefix
    a_first_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move && r_s1.first |=> r_out_count <= t_total'(1))
        else $error("first element produced a count above one");
`endif

endmodule

`default_nettype wire

### dv/pxsc_check_pkg.sv
// ----------------------------------------------------------------------------
// pxsc_check_pkg
// Running subarray-count predictor and result checker for the prefix-XOR
// subarray counter testbench.
// ----------------------------------------------------------------------------
package pxsc_check_pkg;
    import pxsc_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct {
        t_total count;
        logic   done;
    } t_count_item;

    class subarray_count_board;
        t_key        target;
        t_key        prefix;
        t_hcnt       seen [HIST_DEPTH];
        t_total      total;
        t_count_item expected_counts [$];
        int          mismatches;

        function new();
            target     = '0;
            mismatches = 0;
            clear_array();
        endfunction

        // empty prefix counts as seen once
        function void clear_array();
            foreach (seen[k]) begin
                seen[k] = (k == 0) ? t_hcnt'(1) : t_hcnt'(0);
            end
            prefix = '0;
            total  = '0;
        endfunction

        function void set_target(input logic [FIELD_BITS-1:0] data);
            target = t_key'(data);
        endfunction

        function int pending();
            return expected_counts.size();
        endfunction

        function void flag(input string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("ERROR: %s", msg);
            end
        endfunction

        // fold one accepted element into the running count
        function void note_element(input logic [FIELD_BITS-1:0] value,
                                   input logic first, input logic last);
            t_key              seek;
            logic [TOTAL_BITS:0] sum;
            t_count_item       item;
            if (first) begin
                clear_array();
            end
            prefix = prefix ^ t_key'(value);
            seek   = prefix ^ target;
            sum    = {1'b0, total} + (TOTAL_BITS + 1)'(seen[seek]);
            total  = sum[TOTAL_BITS] ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
            if (seen[prefix] != HIST_MAX) begin
                seen[prefix] = seen[prefix] + 1'b1;
            end
            item.count = total;
            item.done  = last;
            expected_counts.push_back(item);
        endfunction

        function void check_count(input t_total count, input logic done);
            t_count_item want;
            if (expected_counts.size() == 0) begin
                flag($sformatf("result with nothing outstanding: count %0d done %0b",
                               count, done));
                return;
            end
            want = expected_counts.pop_front();
            if (count !== want.count) begin
                flag($sformatf("match_count expected %0d got %0d", want.count, count));
            end
            if (done !== want.done) begin
                flag($sformatf("done_res expected %0b got %0b", want.done, done));
            end
        endfunction
    endclass

endpackage

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the prefix-XOR subarray counter: directed arrays
// and random arrays under bursty input and a stalling receiver, each result
// checked against a running predictor.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pxsc_pkg::*;
    import pxsc_check_pkg::*;

    localparam int HOLD_CYCLES = 120;   // long receiver hold-off
    localparam int STUCK_LIMIT = 4000;  // cycles with no transaction at all
    localparam int PHASE_ITEMS = 250;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [FIELD_BITS-1:0] i_cfg_data;

    pxsc_in_if  item_ch ();
    pxsc_out_if res_ch ();

    prefix_xor_subarray_counter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_ch.sink),
        .o_res      (res_ch.source)
    );

    subarray_count_board board = new();

    bit pace_on      = 1'b1;  // sender works in bursts with gaps
    int burst_left   = 0;
    bit hold_off_req = 1'b0;  // asks the receiver for its long hold-off
    int stuck_cycles = 0;

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitors and watchdog. Sample at the rising edge, before the block's
    // own updates land, so every transaction is seen exactly as accepted.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (item_ch.valid && item_ch.ready) begin
            board.note_element(item_ch.value, item_ch.first, item_ch.last);
        end
        if (res_ch.valid && res_ch.ready) begin
            board.check_count(res_ch.match_count, res_ch.done_res);
        end
        // count cycles with no transaction on either side; a hung block ends here
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall on a pattern of its own, in segments of random length
    // and random stall rate, some segments never stalling. On request, hold
    // ready low for a long stretch counted here, so the block fills up.
    // ------------------------------------------------------------------------
    initial begin
        int segment_left;
        int stall_pct;
        int hold_left;
        res_ch.ready <= 1'b0;
        segment_left = 0;
        stall_pct    = 0;
        hold_left    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                if (segment_left == 0) begin
                    segment_left = $urandom_range(16, 256);
                    case ($urandom_range(4))
                        0, 1: stall_pct = 0;
                        2: stall_pct = 25;
                        3: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                segment_left--;
                res_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks. Every task starts and ends at a falling edge; inputs only
    // change there.
    // ------------------------------------------------------------------------

    // Offer one element and hold it until the block takes it. When pacing,
    // drop valid for a random gap once the current burst runs out.
    task automatic send_element(input logic [FIELD_BITS-1:0] v,
                                input logic f, input logic l);
        int gap;
        item_ch.valid <= 1'b1;
        item_ch.value <= v;
        item_ch.first <= f;
        item_ch.last  <= l;
        @(posedge i_clk);
        while (item_ch.ready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
        if (pace_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(1, 24);
                gap        = $urandom_range(1, 6);
                item_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // Stop offering, wait for every outstanding count, then let the pipeline
    // run dry.
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write the target; only called while the block is idle.
    task automatic write_target(input logic [FIELD_BITS-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        board.set_target(v);
        i_cfg_we   <= 1'b0;
    endtask

    // One run of elements. Values come from a masked alphabet so prefixes
    // repeat often; some elements also carry the target so matches turn up
    // whatever the mask.
    task automatic send_array(input int len, input bit mark_first, input bit mark_last,
                              input logic [FIELD_BITS-1:0] mask);
        int                    n;
        logic [FIELD_BITS-1:0] v;
        for (n = 0; n < len; n++) begin
            v = FIELD_BITS'($urandom) & mask;
            if ($urandom_range(3) == 0) begin
                v = v ^ board.target;
            end
            send_element(v, mark_first && (n == 0), mark_last && (n == len - 1));
        end
    endtask

    // Mostly well-formed arrays with random content; the rest continue an
    // array without a first mark or leave one open with no last mark.
    task automatic run_random_phase(input logic [FIELD_BITS-1:0] tgt, input int quota,
                                    input bit paced, input bit with_hold);
        int                    sent;
        int                    len;
        int                    kind;
        logic [FIELD_BITS-1:0] mask;
        settle();
        write_target(tgt);
        pace_on = paced;
        if (with_hold) begin
            hold_off_req = 1'b1;
        end
        sent = 0;
        while (sent < quota) begin
            kind = $urandom_range(99);
            len  = ($urandom_range(7) == 0) ? $urandom_range(41, 160)
                                             : $urandom_range(1, 40);
            case ($urandom_range(4))
                0: mask = 8'h01;
                1: mask = 8'h03;
                2: mask = 8'h0F;
                3: mask = 8'hFF;
                default: mask = FIELD_BITS'($urandom);
            endcase
            if (kind < 85) begin
                send_array(len, 1'b1, 1'b1, mask);
            end else if (kind < 95) begin
                len = $urandom_range(1, 8);
                send_array(len, 1'b0, 1'($urandom_range(1)), mask);
            end else begin
                send_array(len, 1'b1, 1'b0, mask);
            end
            sent += len;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        item_ch.valid <= 1'b0;
        item_ch.value <= '0;
        item_ch.first <= 1'b0;
        item_ch.last  <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Right after reset with no first mark: continue the reset array,
        // target still at its reset value. Carry on past a last mark too.
        send_element(8'h00, 1'b0, 1'b0);
        send_element(8'hFF, 1'b0, 1'b0);
        send_element(8'hFF, 1'b0, 1'b1);
        send_element(8'hAA, 1'b0, 1'b0);
        send_element(8'hAA, 1'b0, 1'b1);

        // Top target: single-element array, then a short mixed one.
        settle();
        write_target(8'hFF);
        send_element(8'hFF, 1'b1, 1'b1);
        send_element(8'h0F, 1'b1, 1'b0);
        send_element(8'hF0, 1'b0, 1'b0);
        send_element(8'h55, 1'b0, 1'b0);
        send_element(8'hAA, 1'b0, 1'b0);
        send_element(8'hFF, 1'b0, 1'b1);

        // Zero target over a run of zeros, where every subarray counts, then two short arrays.
        settle();
        write_target(8'h00);
        send_element(8'h00, 1'b1, 1'b0);
        send_element(8'h00, 1'b0, 1'b0);
        send_element(8'h00, 1'b0, 1'b0);
        send_element(8'h00, 1'b0, 1'b1);
        send_element(8'h80, 1'b1, 1'b1);
        send_element(8'h01, 1'b1, 1'b0);
        send_element(8'h01, 1'b0, 1'b1);

        // Random arrays over several targets; the first phase opens with the
        // long receiver hold-off while the sender keeps offering.
        run_random_phase(8'hFF, PHASE_ITEMS, 1'b1, 1'b1);
        run_random_phase(8'h00, PHASE_ITEMS, 1'b1, 1'b0);
        run_random_phase(FIELD_BITS'($urandom), PHASE_ITEMS, 1'b0, 1'b0);
        run_random_phase(FIELD_BITS'($urandom_range(1, 15)), PHASE_ITEMS, 1'b1, 1'b0);
        run_random_phase(FIELD_BITS'($urandom), PHASE_ITEMS, 1'b1, 1'b0);

        // Drain; the watchdog bounds the wait.
        settle();
        if (board.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### files.f
hdl/pxsc_pkg.sv
hdl/pxsc_in_if.sv
hdl/pxsc_out_if.sv
hdl/pxsc_hist_store.sv
hdl/prefix_xor_subarray_counter.sv
dv/pxsc_check_pkg.sv
dv/tb_top.sv
